// ----- rtl/psm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psm_pkg
// shared constants for the pcm sample channel mixer
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int MEM_DEPTH_DEF = 4096;

    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_PLAY_ONE   = 3'd1;
    localparam logic [2:0] CMD_PLAY_MUSIC = 3'd2;
    localparam logic [2:0] CMD_STOP_CHAN  = 3'd3;
    localparam logic [2:0] CMD_SET_VOL    = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;
    localparam logic [2:0] CMD_STOP_MUSIC = 3'd6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ONE   = 2'd1;
    localparam logic [1:0] MODE_MUSIC = 2'd2;

    localparam logic [3:0] MUSIC_NONE = 4'hf;
    localparam logic [9:0] SCALE_RESET = 10'd256;

endpackage
`default_nettype wire

// ----- rtl/pcm_sample_channel_mixer_core.sv -----
`default_nettype none
// An accepted command runs ST_CHK (twice for play music), then ST_OUT raises
// out_valid; a tick walks the channels in ST_RD, active ones also via ST_MUL and
// ST_ACC, then ST_SCL and ST_FIN. One transaction at a time, the next accepted in
// idle after the result is taken; tick cost is set by the channel walk reading
// the sample ram per channel. Reset: all channels idle, music slot none, master
// scale 256; sample ram has no reset and holds whatever was loaded.
// ----------------------------------------------------------------------------
// pcm_sample_channel_mixer_core
// multichannel signed pcm mixer over a loadable sample memory
// ----------------------------------------------------------------------------
module pcm_sample_channel_mixer_core #(
    parameter int CHANNELS  = psm_pkg::CHANNELS_DEF,
    parameter int MEM_DEPTH = psm_pkg::MEM_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [9:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        cmd,
    input  wire logic [11:0]       mem_address,
    input  wire logic signed [7:0] sample_byte,
    input  wire logic [12:0]       sample_length,
    input  wire logic [15:0]       gain,
    input  wire logic [3:0]        channel_number,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [3:0]      channel_index,
    output logic signed [7:0]      mixed_sample
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_SCL  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]  state_reg;
    logic [9:0]  scale_reg;
    logic [1:0]  mode_reg   [CHANNELS];
    logic        rsv_reg    [CHANNELS];
    logic [15:0] vol_reg    [CHANNELS];
    logic [12:0] start_reg  [CHANNELS];
    logic [12:0] end_reg    [CHANNELS];
    logic [12:0] cur_reg    [CHANNELS];
    logic [3:0]  music_reg;
    logic [CW:0] ch_reg;
    logic [15:0] sum_reg;
    logic signed [31:0] prod_reg;
    logic signed [3:0]  idx_reg;
    logic signed [7:0]  smp_reg;
    logic [2:0]  cmd_reg;
    logic [12:0] a_reg;
    logic [12:0] len_reg;
    logic [15:0] gain_reg;
    logic [3:0]  cn_reg;
    logic        music_req_reg;
    logic signed [7:0] byte_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_rdata;
    logic [CW-1:0]  ch;
    logic           free_found;
    logic [CW-1:0]  free_idx;
    logic [13:0]    end_raw;
    logic [12:0]    end_clip;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] mul_p;

    assign ch       = ch_reg[CW-1:0];
    assign in_ready = (state_reg == ST_IDLE);

    psm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (byte_reg),
        .rdata (ram_rdata)
    );

    // ram address: load target or cursor of current channel
    always_comb
    begin
        ram_we   = (state_reg == ST_CHK) && (cmd_reg == psm_pkg::CMD_LOAD)
                   && (a_reg < 13'(MEM_DEPTH));
        ram_addr = (cmd_reg == psm_pkg::CMD_LOAD) ? a_reg[AW-1:0] : cur_reg[ch][AW-1:0];
    end

    // first free channel search, small priority encoder, and clipped play end address
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (!rsv_reg[i] && mode_reg[i] == psm_pkg::MODE_IDLE)
            begin
                free_found = 1'b1;
                free_idx   = CW'(i);
            end
        end
        end_raw  = {1'b0, a_reg} + {1'b0, len_reg[12:2], 2'b00};
        end_clip = (end_raw > 14'(MEM_DEPTH)) ? 13'(MEM_DEPTH) : end_raw[12:0];
    end

    // shared multiplier: channel volume or master scale
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = 32'(signed'(ram_rdata));
            mul_b = {16'd0, vol_reg[ch]};
        end
        else
        begin
            mul_a = 32'(signed'(sum_reg));
            mul_b = {22'd0, scale_reg};
        end
        mul_p = mul_a * mul_b;
    end

    // sequencer and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scale_reg <= psm_pkg::SCALE_RESET;
            music_reg <= psm_pkg::MUSIC_NONE;
            out_valid <= 1'b0;
            ch_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i]  <= psm_pkg::MODE_IDLE;
                rsv_reg[i]   <= 1'b0;
                vol_reg[i]   <= '0;
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
                cur_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= cmd;
                        a_reg         <= {1'b0, mem_address};
                        len_reg       <= sample_length;
                        gain_reg      <= gain;
                        cn_reg        <= channel_number;
                        music_req_reg <= 1'b0;
                        byte_reg      <= sample_byte;
                        idx_reg       <= -4'sd1;
                        smp_reg       <= '0;
                        sum_reg       <= '0;
                        ch_reg        <= '0;
                        state_reg     <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    state_reg <= ST_OUT;
                    case (cmd_reg)
                        psm_pkg::CMD_PLAY_MUSIC:
                        begin
                            // stop current music, then claim next cycle
                            if (music_reg < 4'(CHANNELS))
                            begin
                                mode_reg[music_reg[CW-1:0]]  <= psm_pkg::MODE_IDLE;
                                rsv_reg[music_reg[CW-1:0]]   <= 1'b0;
                                vol_reg[music_reg[CW-1:0]]   <= '0;
                                start_reg[music_reg[CW-1:0]] <= '0;
                                end_reg[music_reg[CW-1:0]]   <= '0;
                                cur_reg[music_reg[CW-1:0]]   <= '0;
                            end
                            music_reg     <= psm_pkg::MUSIC_NONE;
                            cmd_reg       <= psm_pkg::CMD_PLAY_ONE;
                            music_req_reg <= 1'b1;
                            state_reg     <= ST_CHK;
                        end
                        psm_pkg::CMD_PLAY_ONE:
                        begin
                            if (a_reg < 13'(MEM_DEPTH) && len_reg[12:2] != '0 && free_found)
                            begin
                                mode_reg[free_idx]  <= music_req_reg ? psm_pkg::MODE_MUSIC
                                                                     : psm_pkg::MODE_ONE;
                                rsv_reg[free_idx]   <= music_req_reg;
                                vol_reg[free_idx]   <= gain_reg;
                                start_reg[free_idx] <= a_reg;
                                end_reg[free_idx]   <= end_clip;
                                cur_reg[free_idx]   <= a_reg;
                                idx_reg             <= 4'(free_idx);
                                if (music_req_reg)
                                begin
                                    music_reg <= 4'(free_idx);
                                end
                            end
                        end
                        psm_pkg::CMD_STOP_CHAN:
                        begin
                            if (cn_reg < 4'(CHANNELS))
                            begin
                                if (cn_reg == music_reg)
                                begin
                                    music_reg <= psm_pkg::MUSIC_NONE;
                                end
                                mode_reg[cn_reg[CW-1:0]]  <= psm_pkg::MODE_IDLE;
                                rsv_reg[cn_reg[CW-1:0]]   <= 1'b0;
                                vol_reg[cn_reg[CW-1:0]]   <= '0;
                                start_reg[cn_reg[CW-1:0]] <= '0;
                                end_reg[cn_reg[CW-1:0]]   <= '0;
                                cur_reg[cn_reg[CW-1:0]]   <= '0;
                            end
                        end
                        psm_pkg::CMD_SET_VOL:
                        begin
                            if (cn_reg < 4'(CHANNELS))
                            begin
                                vol_reg[cn_reg[CW-1:0]] <= gain_reg;
                            end
                        end
                        psm_pkg::CMD_STOP_MUSIC:
                        begin
                            if (music_reg < 4'(CHANNELS))
                            begin
                                mode_reg[music_reg[CW-1:0]]  <= psm_pkg::MODE_IDLE;
                                rsv_reg[music_reg[CW-1:0]]   <= 1'b0;
                                vol_reg[music_reg[CW-1:0]]   <= '0;
                                start_reg[music_reg[CW-1:0]] <= '0;
                                end_reg[music_reg[CW-1:0]]   <= '0;
                                cur_reg[music_reg[CW-1:0]]   <= '0;
                            end
                            music_reg <= psm_pkg::MUSIC_NONE;
                        end
                        psm_pkg::CMD_TICK:
                        begin
                            state_reg <= ST_RD;
                            ch_reg    <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_RD:
                begin
                    // channel walk: end check, then issue ram read
                    if (ch_reg == (CW+1)'(CHANNELS))
                    begin
                        state_reg <= ST_SCL;
                    end
                    else if (mode_reg[ch] == psm_pkg::MODE_IDLE)
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                    else if (cur_reg[ch] >= end_reg[ch] && mode_reg[ch] == psm_pkg::MODE_ONE)
                    begin
                        mode_reg[ch]  <= psm_pkg::MODE_IDLE;
                        rsv_reg[ch]   <= 1'b0;
                        vol_reg[ch]   <= '0;
                        start_reg[ch] <= '0;
                        end_reg[ch]   <= '0;
                        cur_reg[ch]   <= '0;
                        ch_reg        <= ch_reg + 1'b1;
                    end
                    else if (cur_reg[ch] >= end_reg[ch])
                    begin
                        cur_reg[ch] <= start_reg[ch];
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg    <= mul_p;
                    cur_reg[ch] <= cur_reg[ch] + 1'b1;
                    state_reg   <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg   <= sum_reg + prod_reg[23:8];
                    ch_reg    <= ch_reg + 1'b1;
                    state_reg <= ST_RD;
                end
                ST_SCL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    smp_reg   <= prod_reg[15:8];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid     <= 1'b1;
                        channel_index <= idx_reg;
                        mixed_sample  <= smp_reg;
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/psm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psm_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, old word returned on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pcm sample channel mixer: a directed table of
// corner commands, then random command streams under several master scales
// and idle patterns, results checked against typed values or a mixer model
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] CMD_NOP = 3'd7;
    localparam int         NCHAN   = psm_pkg::CHANNELS_DEF;
    localparam int         DEPTH   = psm_pkg::MEM_DEPTH_DEF;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [12:0] len;
        logic [15:0] vol;
        logic [3:0]  chan;
    } mix_cmd_t;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] smp;
    } mix_out_t;

    typedef struct packed {
        mix_cmd_t   c;
        logic       typed;
        mix_out_t   want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [9:0]         cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic [11:0]        mem_address;
    logic signed [7:0]  sample_byte;
    logic [12:0]        sample_length;
    logic [15:0]        gain;
    logic [3:0]         channel_number;
    logic               out_valid;
    logic               out_ready;
    logic signed [3:0]  channel_index;
    logic signed [7:0]  mixed_sample;

    pcm_sample_channel_mixer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .mem_address    (mem_address),
        .sample_byte    (sample_byte),
        .sample_length  (sample_length),
        .gain           (gain),
        .channel_number (channel_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .channel_index  (channel_index),
        .mixed_sample   (mixed_sample)
    );

    // mixer model state
    logic [7:0]  mdl_mem     [DEPTH];
    logic        mdl_written [DEPTH];
    logic [1:0]  mdl_mode    [NCHAN];
    logic        mdl_rsv     [NCHAN];
    logic [15:0] mdl_vol     [NCHAN];
    logic [11:0] mdl_start   [NCHAN];
    logic [12:0] mdl_end     [NCHAN];
    logic [12:0] mdl_cursor  [NCHAN];
    logic [3:0]  mdl_music;
    logic [9:0]  mdl_scale;

    mix_out_t    pending_results[$];
    int          fail_count;
    int          sender_idle_pct;
    int          receiver_idle_pct;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void free_chan(int c);
        mdl_mode[c]   = psm_pkg::MODE_IDLE;
        mdl_rsv[c]    = 1'b0;
        mdl_vol[c]    = '0;
        mdl_start[c]  = '0;
        mdl_end[c]    = '0;
        mdl_cursor[c] = '0;
    endfunction

    function automatic void stop_music_chan();
        if (mdl_music < NCHAN)
            free_chan(mdl_music);
        mdl_music = psm_pkg::MUSIC_NONE;
    endfunction

    function automatic int claim_chan(mix_cmd_t c, logic [1:0] mode, logic rsv);
        int unsigned rlen;
        int unsigned stop;
        rlen = c.len & 13'h1ffc;
        if (rlen == 0)
            return -1;
        stop = c.addr + rlen;
        if (stop > DEPTH)
            stop = DEPTH;
        for (int i = 0; i < NCHAN; i++)
        begin
            if (!mdl_rsv[i] && mdl_mode[i] == psm_pkg::MODE_IDLE)
            begin
                mdl_mode[i]   = mode;
                mdl_rsv[i]    = rsv;
                mdl_vol[i]    = c.vol;
                mdl_start[i]  = c.addr;
                mdl_end[i]    = stop[12:0];
                mdl_cursor[i] = {1'b0, c.addr};
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] mix_one_tick();
        logic [15:0] sum;
        int          s;
        int          add;
        int          mixed;
        int          scaled;
        sum = '0;
        for (int i = 0; i < NCHAN; i++)
        begin
            if (mdl_mode[i] == psm_pkg::MODE_IDLE)
                continue;
            if (mdl_cursor[i] >= mdl_end[i])
            begin
                if (mdl_mode[i] == psm_pkg::MODE_ONE)
                begin
                    free_chan(i);
                    continue;
                end
                mdl_cursor[i] = {1'b0, mdl_start[i]};
            end
            s = (mdl_cursor[i] < DEPTH) ? int'($signed(mdl_mem[mdl_cursor[i][11:0]])) : 0;
            mdl_cursor[i] = mdl_cursor[i] + 13'd1;
            add = (s * int'(mdl_vol[i])) >>> 8;
            sum = sum + add[15:0];
        end
        mixed  = int'($signed(sum));
        scaled = (mixed * int'(mdl_scale)) >>> 8;
        return scaled[7:0];
    endfunction

    // advance the model by one command and return its result
    function automatic mix_out_t mixer_predict(mix_cmd_t c);
        int       id;
        mix_out_t r;
        id    = -1;
        r.smp = '0;
        case (c.op)
            psm_pkg::CMD_LOAD:
            begin
                mdl_mem[c.addr]     = c.data;
                mdl_written[c.addr] = 1'b1;
            end
            psm_pkg::CMD_PLAY_ONE:   id = claim_chan(c, psm_pkg::MODE_ONE, 1'b0);
            psm_pkg::CMD_PLAY_MUSIC:
            begin
                stop_music_chan();
                id = claim_chan(c, psm_pkg::MODE_MUSIC, 1'b1);
                if (id >= 0)
                    mdl_music = id[3:0];
            end
            psm_pkg::CMD_STOP_CHAN:
            begin
                if (c.chan < NCHAN)
                begin
                    if (c.chan == mdl_music)
                        mdl_music = psm_pkg::MUSIC_NONE;
                    free_chan(c.chan);
                end
            end
            psm_pkg::CMD_SET_VOL:    if (c.chan < NCHAN) mdl_vol[c.chan] = c.vol;
            psm_pkg::CMD_TICK:       r.smp = mix_one_tick();
            psm_pkg::CMD_STOP_MUSIC: stop_music_chan();
            default: ;
        endcase
        r.idx = id[3:0];
        return r;
    endfunction

    // true when every byte a play would read has been loaded
    function automatic logic region_loaded(mix_cmd_t c);
        int unsigned stop;
        stop = c.addr + (c.len & 13'h1ffc);
        if (stop > DEPTH)
            stop = DEPTH;
        for (int unsigned a = c.addr; a < stop; a++)
            if (!mdl_written[a])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic mix_cmd_t mk(logic [2:0] op, logic [11:0] addr, logic [7:0] data,
                                    logic [12:0] len, logic [15:0] vol, logic [3:0] chan);
        mix_cmd_t c;
        c.op = op; c.addr = addr; c.data = data; c.len = len; c.vol = vol; c.chan = chan;
        return c;
    endfunction

    // drive one transaction and log its expected result
    task automatic send_cmd(mix_cmd_t c, logic typed, mix_out_t want);
        mix_out_t pred;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        pred = mixer_predict(c);
        pending_results.push_back(typed ? want : pred);
        cmd            <= c.op;
        mem_address    <= c.addr;
        sample_byte    <= c.data;
        sample_length  <= c.len;
        gain           <= c.vol;
        channel_number <= c.chan;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait for all results, let the block settle, then write master scale
    task automatic write_scale(logic [9:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        mdl_scale  = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic mix_cmd_t random_cmd();
        mix_cmd_t c;
        int       pick;
        c.addr = $urandom_range(99) < 80 ? 12'($urandom_range(0, 511)) : 12'($urandom);
        c.data = 8'($urandom);
        c.len  = 13'($urandom);
        c.vol  = 16'($urandom);
        c.chan = $urandom_range(99) < 75 ? 4'($urandom_range(0, 7)) : 4'($urandom);
        pick   = $urandom_range(99);
        if (pick < 35)      c.op = psm_pkg::CMD_LOAD;
        else if (pick < 47) c.op = psm_pkg::CMD_PLAY_ONE;
        else if (pick < 52) c.op = psm_pkg::CMD_PLAY_MUSIC;
        else if (pick < 58) c.op = psm_pkg::CMD_STOP_CHAN;
        else if (pick < 64) c.op = psm_pkg::CMD_SET_VOL;
        else if (pick < 94) c.op = psm_pkg::CMD_TICK;
        else if (pick < 97) c.op = psm_pkg::CMD_STOP_MUSIC;
        else                c.op = CMD_NOP;
        if (c.op == psm_pkg::CMD_PLAY_ONE || c.op == psm_pkg::CMD_PLAY_MUSIC)
        begin
            if ($urandom_range(99) < 85)
            begin
                c.addr = 12'($urandom_range(0, 480));
                c.len  = 13'($urandom_range(0, 40));
            end
            // never let a play read a byte that was not loaded
            if (!region_loaded(c))
            begin
                c.op = psm_pkg::CMD_LOAD;
                for (int a = c.addr; a < DEPTH; a++)
                begin
                    if (!mdl_written[a])
                    begin
                        c.addr = 12'(a);
                        break;
                    end
                end
            end
        end
        return c;
    endfunction

    // receiver backpressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        mix_out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d smp=%0d", $time,
                         channel_index, mixed_sample);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (channel_index !== exp_r.idx)
                begin
                    $display("%0t: channel_index expected %0d actual %0d", $time,
                             $signed(exp_r.idx), channel_index);
                    fail_count++;
                end
                if (mixed_sample !== exp_r.smp)
                begin
                    $display("%0t: mixed_sample expected %0d actual %0d", $time,
                             $signed(exp_r.smp), mixed_sample);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t   rows[$];
        mix_out_t   none_r;
        int         phase_items;
        logic [9:0] scales[6];

        fail_count        = 0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 62;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        cmd            = '0;
        mem_address    = '0;
        sample_byte    = '0;
        sample_length  = '0;
        gain           = '0;
        channel_number = '0;
        out_ready      = 1'b0;
        for (int a = 0; a < DEPTH; a++)
        begin
            mdl_mem[a]     = '0;
            mdl_written[a] = 1'b0;
        end
        for (int i = 0; i < NCHAN; i++)
            free_chan(i);
        mdl_music = psm_pkg::MUSIC_NONE;
        mdl_scale = psm_pkg::SCALE_RESET;
        none_r.idx = 4'hf;
        none_r.smp = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: idle corners first, then play, mix and clamp cases
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_PLAY_ONE, 0, 0, 3, 100, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_STOP_MUSIC, 0, 0, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_STOP_CHAN, 0, 0, 0, 0, 15), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_SET_VOL, 0, 0, 0, 16'hffff, 9), 1'b1, none_r});
        rows.push_back('{mk(CMD_NOP, 12'hfff, 8'hff, 13'h1fff, 16'hffff, 15), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 0, 8'h7f, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 1, 8'h80, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 2, 8'h55, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 3, 8'hff, 0, 0, 0), 1'b1, none_r});
        rows.push_back('{mk(psm_pkg::CMD_PLAY_ONE, 0, 0, 4, 16'hffff, 0), 1'b1,
                         '{4'd0, 8'd0}});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_PLAY_MUSIC, 0, 0, 7, 256, 0), 1'b1,
                         '{4'd1, 8'd0}});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_SET_VOL, 0, 0, 0, 0, 1), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_SET_VOL, 0, 0, 0, 123, 5), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 12'hffc, 8'h01, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 12'hffd, 8'h80, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 12'hffe, 8'h7f, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_LOAD, 12'hfff, 8'hc0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_PLAY_ONE, 12'hffc, 0, 13'd4096, 16'h8000, 0),
                         1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_PLAY_MUSIC, 12'hffc, 0, 8, 16'hffff, 0),
                         1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_STOP_CHAN, 0, 0, 0, 0, 1), 1'b0, none_r});
        rows.push_back('{mk(psm_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none_r});
        foreach (rows[i])
            send_cmd(rows[i].c, rows[i].typed, rows[i].want);

        // random segments under different master scales and idle patterns
        scales = '{10'd0, 10'd1023, 10'd1, 10'($urandom), 10'd512, 10'($urandom)};
        for (int seg = 0; seg < 6; seg++)
        begin
            write_scale(scales[seg]);
            sender_idle_pct   = (seg < 2) ? 30 : (seg < 4) ? 62 : 0;
            receiver_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 30 : 0;
            phase_items = 0;
            while (phase_items < 305)
            begin
                send_cmd(random_cmd(), 1'b0, none_r);
                phase_items++;
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/psm_pkg.sv
rtl/psm_ram.sv
rtl/pcm_sample_channel_mixer_core.sv
verif/testbench.sv
